// ===== rtl/ume_pkg.sv =====
// Package for the UNI/O bus master byte engine: phase and op codes,
// register map, item, result and configuration types. No dependencies.
package ume_pkg;

    localparam int COUNT_WIDTH = 16;
    // Wide enough for any register duration plus one and for the 2^COUNT_WIDTH limit
    localparam int DUR_W = ((COUNT_WIDTH > 16) ? COUNT_WIDTH : 16) + 1;

    localparam int TDATA_W = 16;
    localparam int PADDR_W = 4;

    typedef enum logic [3:0] {
        PH_IDLE_REL,
        PH_IDLE_HIGH,
        PH_STBY_LOW,
        PH_STBY_HIGH,
        PH_GAP,
        PH_HDR_LOW,
        PH_BIT
    } phase_t;

    localparam logic [2:0] OP_STANDBY = 3'd0;
    localparam logic [2:0] OP_GAP     = 3'd1;
    localparam logic [2:0] OP_HEADER  = 3'd2;
    localparam logic [2:0] OP_SEND    = 3'd3;
    localparam logic [2:0] OP_READ    = 3'd4;

    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_START = 1'b1;

    localparam logic [7:0] HEADER_BYTE = 8'h55;

    localparam logic [3:0] BIT_LAST_DATA = 4'd7;
    localparam logic [3:0] BIT_MAK       = 4'd8;
    localparam logic [3:0] BIT_SAK       = 4'd9;

    localparam logic [1:0] REG_QUARTER      = 2'd0;
    localparam logic [1:0] REG_STANDBY_HIGH = 2'd1;
    localparam logic [1:0] REG_SETUP        = 2'd2;
    localparam logic [1:0] REG_HEADER_LOW   = 2'd3;

    localparam logic [7:0]  RST_QUARTER      = 8'd10;
    localparam logic [15:0] RST_STANDBY_HIGH = 16'd605;
    localparam logic [15:0] RST_SETUP        = 16'd15;
    localparam logic [15:0] RST_HEADER_LOW   = 16'd10;

    typedef struct packed {
        logic [7:0]  quarter_bit_ticks;
        logic [15:0] standby_high_ticks;
        logic [15:0] setup_ticks;
        logic [15:0] header_low_ticks;
    } cfg_t;

    typedef struct packed {
        logic       kind;
        logic       bus_in;
        logic [2:0] op;
        logic [7:0] tx_byte;
        logic       mak;
    } item_t;

    typedef struct packed {
        logic       bus_drive;
        logic       bus_enable;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       sak_ok;
        logic       rejected;
    } result_t;

endpackage

// ===== rtl/ume_cfg_regs.sv =====
// APB register file for the UNI/O byte engine timing registers.
// Depends on ume_pkg.
module ume_cfg_regs
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ume_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output ume_pkg::cfg_t               cfg
);

    ume_pkg::cfg_t cfg_reg;
    logic          wr_en;
    logic [1:0]    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.quarter_bit_ticks  <= ume_pkg::RST_QUARTER;
            cfg_reg.standby_high_ticks <= ume_pkg::RST_STANDBY_HIGH;
            cfg_reg.setup_ticks        <= ume_pkg::RST_SETUP;
            cfg_reg.header_low_ticks   <= ume_pkg::RST_HEADER_LOW;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                ume_pkg::REG_QUARTER:      cfg_reg.quarter_bit_ticks  <= pwdata[7:0];
                ume_pkg::REG_STANDBY_HIGH: cfg_reg.standby_high_ticks <= pwdata[15:0];
                ume_pkg::REG_SETUP:        cfg_reg.setup_ticks        <= pwdata[15:0];
                ume_pkg::REG_HEADER_LOW:   cfg_reg.header_low_ticks   <= pwdata[15:0];
                default:                   cfg_reg                    <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            ume_pkg::REG_QUARTER:      prdata = {24'd0, cfg_reg.quarter_bit_ticks};
            ume_pkg::REG_STANDBY_HIGH: prdata = {16'd0, cfg_reg.standby_high_ticks};
            ume_pkg::REG_SETUP:        prdata = {16'd0, cfg_reg.setup_ticks};
            ume_pkg::REG_HEADER_LOW:   prdata = {16'd0, cfg_reg.header_low_ticks};
            default:                   prdata = 32'd0;
        endcase
    end

endmodule

// ===== rtl/ume_engine.sv =====
// Phase sequencer and bit engine: holds the bus state and computes the
// result of one item in a single step. Depends on ume_pkg.
module ume_engine
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  ume_pkg::item_t    item,
    input  ume_pkg::cfg_t     cfg,
    output ume_pkg::result_t  result
);

    localparam int CW = ume_pkg::COUNT_WIDTH;
    localparam int DW = ume_pkg::DUR_W;

    ume_pkg::phase_t  phase_reg, phase_next;
    logic [CW-1:0]    tick_reg, tick_next;
    logic [3:0]       bit_index_reg, bit_index_next;
    logic [7:0]       shift_reg, shift_next;
    logic             first_sample_reg, first_sample_next;
    logic             held_mak_reg, held_mak_next;
    logic [2:0]       held_op_reg, held_op_next;
    logic [7:0]       last_rx_reg, last_rx_next;
    logic             last_sak_reg, last_sak_next;

    logic             idle;
    logic             done;
    logic             rej;
    logic             bit_val;
    logic [7:0]       q;
    logic [DW-1:0]    q_ext;
    logic [DW-1:0]    q3_ext;
    logic [DW-1:0]    raw_dur;
    logic [DW-1:0]    dur;
    logic [DW-1:0]    pos;
    logic [DW-1:0]    pos_inc;
    logic [DW-1:0]    half_pos;
    logic [DW-1:0]    two_q;
    logic             released;
    logic             bit_word;

    localparam logic [DW-1:0] DUR_LIMIT = DW'(1) << CW;

    assign idle    = (phase_reg == ume_pkg::PH_IDLE_REL) || (phase_reg == ume_pkg::PH_IDLE_HIGH);
    assign q       = (cfg.quarter_bit_ticks == 8'd0) ? 8'd1 : cfg.quarter_bit_ticks;
    assign q_ext   = DW'(q);
    assign q3_ext  = q_ext + (q_ext << 1);
    assign two_q   = q_ext << 1;
    assign pos     = DW'(tick_reg);
    assign pos_inc = pos + DW'(1);

    always_comb
    begin
        unique case (phase_reg)
            ume_pkg::PH_STBY_LOW:  raw_dur = DW'(cfg.setup_ticks);
            ume_pkg::PH_STBY_HIGH: raw_dur = DW'(cfg.standby_high_ticks);
            ume_pkg::PH_GAP:       raw_dur = DW'(cfg.setup_ticks);
            ume_pkg::PH_HDR_LOW:   raw_dur = DW'(cfg.header_low_ticks);
            default:               raw_dur = DW'({q, 2'b00});
        endcase
        if (raw_dur == '0)
            dur = DW'(1);
        else if (raw_dur > DUR_LIMIT)
            dur = DUR_LIMIT;
        else
            dur = raw_dur;
    end

    // Next state
    always_comb
    begin
        phase_next        = phase_reg;
        tick_next         = tick_reg;
        bit_index_next    = bit_index_reg;
        shift_next        = shift_reg;
        first_sample_next = first_sample_reg;
        held_mak_next     = held_mak_reg;
        held_op_next      = held_op_reg;
        last_rx_next      = last_rx_reg;
        last_sak_next     = last_sak_reg;
        done              = 1'b0;
        rej               = 1'b0;
        bit_val           = 1'b0;

        if (item.kind == ume_pkg::KIND_TICK)
        begin
            if (!idle)
            begin
                if (phase_reg == ume_pkg::PH_BIT)
                begin
                    if (pos == q_ext)
                        first_sample_next = item.bus_in;
                    // low then high decodes as one
                    if (pos == q3_ext)
                        bit_val = item.bus_in & ~first_sample_reg;
                end
                if (pos_inc >= dur)
                begin
                    tick_next = '0;
                    unique case (phase_reg)
                        ume_pkg::PH_STBY_LOW:  phase_next = ume_pkg::PH_STBY_HIGH;
                        ume_pkg::PH_STBY_HIGH:
                        begin
                            phase_next = ume_pkg::PH_IDLE_HIGH;
                            done       = 1'b1;
                        end
                        ume_pkg::PH_GAP:
                        begin
                            phase_next = ume_pkg::PH_IDLE_HIGH;
                            done       = 1'b1;
                        end
                        ume_pkg::PH_HDR_LOW:
                        begin
                            phase_next     = ume_pkg::PH_BIT;
                            bit_index_next = 4'd0;
                        end
                        default:
                        begin
                            if (bit_index_reg == ume_pkg::BIT_SAK)
                            begin
                                // header acknowledge slot is not kept
                                if (held_op_reg != ume_pkg::OP_HEADER)
                                    last_sak_next = bit_val;
                                phase_next     = ume_pkg::PH_IDLE_HIGH;
                                bit_index_next = 4'd0;
                                done           = 1'b1;
                            end
                            else
                            begin
                                if (bit_index_reg <= ume_pkg::BIT_LAST_DATA)
                                begin
                                    if (held_op_reg == ume_pkg::OP_READ)
                                    begin
                                        shift_next = {shift_reg[6:0], bit_val};
                                        if (bit_index_reg == ume_pkg::BIT_LAST_DATA)
                                            last_rx_next = {shift_reg[6:0], bit_val};
                                    end
                                    else
                                        shift_next = {shift_reg[6:0], 1'b0};
                                end
                                bit_index_next = bit_index_reg + 4'd1;
                            end
                        end
                    endcase
                end
                else
                    tick_next = pos_inc[CW-1:0];
            end
        end
        else if (!idle)
            rej = 1'b1;
        else if (item.op <= ume_pkg::OP_READ)
        begin
            held_op_next      = item.op;
            tick_next         = '0;
            bit_index_next    = 4'd0;
            first_sample_next = 1'b0;
            unique case (item.op)
                ume_pkg::OP_STANDBY: phase_next = ume_pkg::PH_STBY_LOW;
                ume_pkg::OP_GAP:     phase_next = ume_pkg::PH_GAP;
                ume_pkg::OP_HEADER:
                begin
                    phase_next    = ume_pkg::PH_HDR_LOW;
                    shift_next    = ume_pkg::HEADER_BYTE;
                    held_mak_next = 1'b1;
                end
                ume_pkg::OP_SEND:
                begin
                    phase_next    = ume_pkg::PH_BIT;
                    shift_next    = item.tx_byte;
                    held_mak_next = item.mak;
                end
                default:
                begin
                    phase_next    = ume_pkg::PH_BIT;
                    shift_next    = 8'd0;
                    held_mak_next = item.mak;
                end
            endcase
        end
    end

    // Outputs: line level and flags after this item
    assign half_pos = DW'(tick_next);
    assign released = (bit_index_next == ume_pkg::BIT_SAK) ||
                      ((bit_index_next <= ume_pkg::BIT_LAST_DATA) &&
                       (held_op_next == ume_pkg::OP_READ));
    assign bit_word = (bit_index_next == ume_pkg::BIT_MAK) ? held_mak_next : shift_next[7];

    always_comb
    begin
        result.bus_drive  = 1'b0;
        result.bus_enable = 1'b0;
        unique case (phase_next)
            ume_pkg::PH_IDLE_HIGH, ume_pkg::PH_STBY_HIGH, ume_pkg::PH_GAP:
            begin
                result.bus_drive  = 1'b1;
                result.bus_enable = 1'b1;
            end
            ume_pkg::PH_STBY_LOW, ume_pkg::PH_HDR_LOW:
            begin
                result.bus_drive  = 1'b0;
                result.bus_enable = 1'b1;
            end
            ume_pkg::PH_BIT:
            begin
                if (!released)
                begin
                    // complement in the first half, true level in the second
                    result.bus_drive  = (half_pos < two_q) ? ~bit_word : bit_word;
                    result.bus_enable = 1'b1;
                end
            end
            default:
            begin
                result.bus_drive  = 1'b0;
                result.bus_enable = 1'b0;
            end
        endcase
        result.busy_res = (phase_next != ume_pkg::PH_IDLE_REL) &&
                          (phase_next != ume_pkg::PH_IDLE_HIGH);
        result.done_res = done;
        result.rx_byte  = last_rx_next;
        result.sak_ok   = last_sak_next;
        result.rejected = rej;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= ume_pkg::PH_IDLE_REL;
            tick_reg         <= '0;
            bit_index_reg    <= 4'd0;
            shift_reg        <= 8'd0;
            first_sample_reg <= 1'b0;
            held_mak_reg     <= 1'b0;
            held_op_reg      <= 3'd0;
            last_rx_reg      <= 8'd0;
            last_sak_reg     <= 1'b0;
        end
        else if (step)
        begin
            phase_reg        <= phase_next;
            tick_reg         <= tick_next;
            bit_index_reg    <= bit_index_next;
            shift_reg        <= shift_next;
            first_sample_reg <= first_sample_next;
            held_mak_reg     <= held_mak_next;
            held_op_reg      <= held_op_next;
            last_rx_reg      <= last_rx_next;
            last_sak_reg     <= last_sak_next;
        end
    end

`ifndef SYNTH
    a_bit_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        bit_index_reg <= ume_pkg::BIT_SAK)
        else $error("bit index past SAK slot");

    a_bit_index_in_bit: assert property (@(posedge clk) disable iff (!rst_n)
        (bit_index_reg != 4'd0) |-> (phase_reg == ume_pkg::PH_BIT))
        else $error("bit index set outside bit phase");

    a_idle_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
        idle |-> (tick_reg == '0))
        else $error("tick count nonzero while idle");

    a_start_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (step && idle && (item.kind == ume_pkg::KIND_START) &&
         (item.op <= ume_pkg::OP_READ)) |=> !idle)
        else $error("accepted start did not leave idle");

    a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (step && done) |=> (phase_reg == ume_pkg::PH_IDLE_HIGH))
        else $error("done without return to idle high");
`endif

endmodule

// ===== rtl/unio_bus_master_byte_engine.sv =====
// Top level of the UNI/O bus master byte engine: stream input register,
// engine, result register and APB registers. Depends on ume_pkg,
// ume_cfg_regs and ume_engine.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------
//  s_      | in        | s_tvalid/s_tready  | s_tuser kind, s_tdata item fields
//  m_      | out       | m_tvalid/m_tready  | m_tdata result fields
//  apb     | in        | psel/penable       | paddr, pwdata, prdata (regs at 4*i)
//
// One item per clock while m_tready holds: an item is registered in the input
// register, and the engine updates its state and the result register in the same
// step. A stalled result register holds the input register, which backs up
// s_tready only when both are full.
// Reset (rst_n, async) leaves the line released and both registers empty.
module unio_bus_master_byte_engine
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // [0] bus_in, [3:1] op, [11:4] tx_byte, [12] mak, [15:13] zero
    input  logic [ume_pkg::TDATA_W-1:0] s_tdata,
    // [0] kind
    input  logic                        s_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // [0] bus_drive, [1] bus_enable, [2] busy_res, [3] done_res,
    // [11:4] rx_byte, [12] sak_ok, [13] rejected, [15:14] zero
    output logic [ume_pkg::TDATA_W-1:0] m_tdata,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ume_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    ume_pkg::cfg_t    cfg;
    ume_pkg::item_t   in_item_reg;
    ume_pkg::result_t result;
    ume_pkg::result_t out_reg;
    logic             in_valid_reg;
    logic             out_valid_reg;
    logic             step;

    assign step     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg.rejected, out_reg.sak_ok, out_reg.rx_byte,
                       out_reg.done_res, out_reg.busy_res, out_reg.bus_enable,
                       out_reg.bus_drive};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (step)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers: load on transfer, no reset
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg.kind    <= s_tuser;
            in_item_reg.bus_in  <= s_tdata[0];
            in_item_reg.op      <= s_tdata[3:1];
            in_item_reg.tx_byte <= s_tdata[11:4];
            in_item_reg.mak     <= s_tdata[12];
        end
        if (step)
            out_reg <= result;
    end

    ume_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ume_engine u_engine
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (in_item_reg),
        .cfg    (cfg),
        .result (result)
    );

`ifndef SYNTH
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |=> out_valid_reg)
        else $error("pending result dropped");

    a_step_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid_reg)
        else $error("processed item left no result");

    a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !m_tready) |-> !s_tready)
        else $error("input taken while both stages stalled");
`endif

endmodule

// ===== tb/unio_bus_master_byte_engine_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the UNI/O bus master byte engine: tick and start items on the
// input stream, APB register writes, every result checked against a local engine model.
// Depends on ume_pkg and unio_bus_master_byte_engine only.
module unio_bus_master_byte_engine_tb;

    localparam int CW              = ume_pkg::COUNT_WIDTH;
    localparam int WATCHDOG_CYCLES = 1000;
    localparam int RANDOM_ITEMS    = 250;
    localparam int MAX_REPORTS     = 10;

    // op codes the engine does not know
    localparam logic [2:0] OP_UNUSED_LO = 3'd5;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;

    logic                        clk      = 1'b0;
    logic                        rst_n    = 1'b0;
    logic                        s_tvalid = 1'b0;
    logic                        s_tready;
    logic [ume_pkg::TDATA_W-1:0] s_tdata  = '0;
    logic                        s_tuser  = 1'b0;
    logic                        m_tvalid;
    logic                        m_tready = 1'b0;
    logic [ume_pkg::TDATA_W-1:0] m_tdata;
    logic                        psel     = 1'b0;
    logic                        penable  = 1'b0;
    logic                        pwrite   = 1'b0;
    logic [ume_pkg::PADDR_W-1:0] paddr    = '0;
    logic [31:0]                 pwdata   = '0;
    logic [31:0]                 prdata;
    logic                        pready;

    unio_bus_master_byte_engine dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Engine state as the testbench tracks it
    ume_pkg::phase_t eng_phase;
    logic [CW-1:0]   pos_cnt;
    logic [3:0]      bit_idx;
    logic [7:0]      shreg;
    logic            first_smp;
    logic            mak_q;
    logic [2:0]      op_q;
    logic [7:0]      rx_q;
    logic            sak_q;
    ume_pkg::cfg_t   cfg;

    ume_pkg::result_t pending_bus_results[$];
    int               mismatches   = 0;
    int               items_sent   = 0;
    int               stall_cycles = 0;
    bit               steady       = 1'b0;
    int               noise_pct    = 0;
    logic [7:0]       resp_byte    = '0;
    logic             resp_sak     = 1'b0;

    function automatic int quarter_len();
        return (cfg.quarter_bit_ticks == 0) ? 1 : int'(cfg.quarter_bit_ticks);
    endfunction

    function automatic int clamp_len(int d);
        if (d == 0)
            return 1;
        if (d > (1 << CW))
            return 1 << CW;
        return d;
    endfunction

    function automatic int phase_len();
        case (eng_phase)
            ume_pkg::PH_STBY_LOW, ume_pkg::PH_GAP:
                return clamp_len(int'(cfg.setup_ticks));
            ume_pkg::PH_STBY_HIGH:
                return clamp_len(int'(cfg.standby_high_ticks));
            ume_pkg::PH_HDR_LOW:
                return clamp_len(int'(cfg.header_low_ticks));
            default:
                return clamp_len(4 * quarter_len());
        endcase
    endfunction

    function automatic logic engine_idle();
        return eng_phase == ume_pkg::PH_IDLE_REL || eng_phase == ume_pkg::PH_IDLE_HIGH;
    endfunction

    function automatic logic advance_tick(logic bus);
        int   p;
        int   q;
        logic smp;
        logic done;
        p    = int'(pos_cnt);
        q    = quarter_len();
        smp  = 1'b0;
        done = 1'b0;
        if (engine_idle())
            return 1'b0;
        if (eng_phase == ume_pkg::PH_BIT)
        begin
            if (p == q)
                first_smp = bus;
            // low then high decodes as one
            if (p == 3 * q)
                smp = bus & ~first_smp;
        end
        if (p + 1 >= phase_len())
        begin
            pos_cnt = '0;
            case (eng_phase)
                ume_pkg::PH_STBY_LOW:
                    eng_phase = ume_pkg::PH_STBY_HIGH;
                ume_pkg::PH_STBY_HIGH, ume_pkg::PH_GAP:
                begin
                    eng_phase = ume_pkg::PH_IDLE_HIGH;
                    done      = 1'b1;
                end
                ume_pkg::PH_HDR_LOW:
                begin
                    eng_phase = ume_pkg::PH_BIT;
                    bit_idx   = '0;
                end
                default:
                begin
                    if (bit_idx == ume_pkg::BIT_SAK)
                    begin
                        // the header acknowledge is not kept
                        if (op_q != ume_pkg::OP_HEADER)
                            sak_q = smp;
                        eng_phase = ume_pkg::PH_IDLE_HIGH;
                        bit_idx   = '0;
                        done      = 1'b1;
                    end
                    else
                    begin
                        if (bit_idx < ume_pkg::BIT_MAK)
                        begin
                            if (op_q == ume_pkg::OP_READ)
                            begin
                                shreg = {shreg[6:0], smp};
                                if (bit_idx == ume_pkg::BIT_LAST_DATA)
                                    rx_q = shreg;
                            end
                            else
                                shreg = {shreg[6:0], 1'b0};
                        end
                        bit_idx = bit_idx + 1'b1;
                    end
                end
            endcase
        end
        else
            pos_cnt = CW'(p + 1);
        return done;
    endfunction

    function automatic ume_pkg::result_t bus_engine_step(ume_pkg::item_t it);
        ume_pkg::result_t r;
        logic             w;
        r = '0;
        if (it.kind == ume_pkg::KIND_TICK)
            r.done_res = advance_tick(it.bus_in);
        else if (!engine_idle())
            r.rejected = 1'b1;
        else if (it.op <= ume_pkg::OP_READ)
        begin
            op_q      = it.op;
            pos_cnt   = '0;
            bit_idx   = '0;
            first_smp = 1'b0;
            case (it.op)
                ume_pkg::OP_STANDBY:
                    eng_phase = ume_pkg::PH_STBY_LOW;
                ume_pkg::OP_GAP:
                    eng_phase = ume_pkg::PH_GAP;
                ume_pkg::OP_HEADER:
                begin
                    eng_phase = ume_pkg::PH_HDR_LOW;
                    shreg     = ume_pkg::HEADER_BYTE;
                    mak_q     = 1'b1;
                end
                ume_pkg::OP_SEND:
                begin
                    eng_phase = ume_pkg::PH_BIT;
                    shreg     = it.tx_byte;
                    mak_q     = it.mak;
                end
                default:
                begin
                    eng_phase = ume_pkg::PH_BIT;
                    shreg     = '0;
                    mak_q     = it.mak;
                end
            endcase
        end
        case (eng_phase)
            ume_pkg::PH_IDLE_HIGH, ume_pkg::PH_STBY_HIGH, ume_pkg::PH_GAP:
            begin
                r.bus_drive  = 1'b1;
                r.bus_enable = 1'b1;
            end
            ume_pkg::PH_STBY_LOW, ume_pkg::PH_HDR_LOW:
                r.bus_enable = 1'b1;
            ume_pkg::PH_BIT:
            begin
                // released in read data bits and in the acknowledge slot
                if (!(bit_idx == ume_pkg::BIT_SAK ||
                      (bit_idx < ume_pkg::BIT_MAK && op_q == ume_pkg::OP_READ)))
                begin
                    w = (bit_idx == ume_pkg::BIT_MAK) ? mak_q : shreg[7];
                    r.bus_drive  = (int'(pos_cnt) < 2 * quarter_len()) ? ~w : w;
                    r.bus_enable = 1'b1;
                end
            end
            default: ;
        endcase
        r.busy_res = !engine_idle();
        r.rx_byte  = rx_q;
        r.sak_ok   = sak_q;
        return r;
    endfunction

    // Line level a responding slave would show on the next tick, with optional noise
    function automatic logic slave_level();
        logic b;
        if (noise_pct != 0 && $urandom_range(99) < noise_pct)
            return 1'($urandom_range(1));
        if (eng_phase != ume_pkg::PH_BIT)
            return 1'b1;
        if (bit_idx == ume_pkg::BIT_SAK)
            b = resp_sak;
        else if (bit_idx < ume_pkg::BIT_MAK)
            b = resp_byte[ume_pkg::BIT_LAST_DATA - bit_idx];
        else
            b = mak_q;
        return (int'(pos_cnt) < 2 * quarter_len()) ? ~b : b;
    endfunction

    task automatic push_item(ume_pkg::item_t it);
        if (!steady && $urandom_range(99) < 8)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.kind;
        s_tdata  <= {3'b000, it.mak, it.tx_byte, it.op, it.bus_in};
        do @(posedge clk); while (!s_tready);
        pending_bus_results.push_back(bus_engine_step(it));
        items_sent++;
    endtask

    task automatic tick(logic bus);
        ume_pkg::item_t it;
        it         = '0;
        it.kind    = ume_pkg::KIND_TICK;
        it.bus_in  = bus;
        it.op      = 3'($urandom);
        it.tx_byte = 8'($urandom);
        it.mak     = 1'($urandom);
        push_item(it);
    endtask

    task automatic start_op(logic [2:0] op, logic [7:0] txb, logic mk);
        ume_pkg::item_t it;
        it.kind    = ume_pkg::KIND_START;
        it.bus_in  = 1'($urandom);
        it.op      = op;
        it.tx_byte = txb;
        it.mak     = mk;
        push_item(it);
    endtask

    task automatic finish_op();
        while (!engine_idle())
            tick(slave_level());
    endtask

    task automatic run_op(logic [2:0] op, logic [7:0] txb, logic mk, logic [7:0] rbyte,
                          logic rsak);
        resp_byte = rbyte;
        resp_sak  = rsak;
        start_op(op, txb, mk);
        finish_op();
    endtask

    // Hold the sender until every result is back, then let the pipeline settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_bus_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [15:0] val);
        drain();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'h0000, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            ume_pkg::REG_QUARTER:      cfg.quarter_bit_ticks  = val[7:0];
            ume_pkg::REG_STANDBY_HIGH: cfg.standby_high_ticks = val;
            ume_pkg::REG_SETUP:        cfg.setup_ticks        = val;
            default:                   cfg.header_low_ticks   = val;
        endcase
    endtask

    // Run an op on a huge register value for a while, then shrink it mid-phase
    task automatic stretch_and_trim(logic [1:0] idx, logic [15:0] big, logic [15:0] trimmed,
                                    logic [2:0] op, int n_ticks);
        cfg_write(idx, big);
        resp_byte = 8'($urandom);
        resp_sak  = 1'($urandom);
        start_op(op, 8'($urandom), 1'($urandom));
        repeat (n_ticks) tick(slave_level());
        drain();
        cfg_write(idx, trimmed);
        finish_op();
    endtask

    task automatic test_defaults();
        // released line after reset: ticks and unknown ops do nothing
        tick(1'b1);
        tick(1'b0);
        start_op(OP_UNUSED_LO, 8'hFF, 1'b1);
        start_op(OP_UNUSED_HI, 8'h00, 1'b0);
        run_op(ume_pkg::OP_SEND, 8'hA5, 1'b0, 8'h00, 1'b1);
        // start while busy is refused
        start_op(ume_pkg::OP_GAP, 8'h00, 1'b0);
        tick(1'b1);
        start_op(ume_pkg::OP_READ, 8'h00, 1'b0);
        finish_op();
    endtask

    task automatic test_zero_registers();
        // zero durations behave as one tick
        cfg_write(ume_pkg::REG_QUARTER, 16'd0);
        cfg_write(ume_pkg::REG_STANDBY_HIGH, 16'd0);
        cfg_write(ume_pkg::REG_SETUP, 16'd0);
        cfg_write(ume_pkg::REG_HEADER_LOW, 16'd0);
        run_op(ume_pkg::OP_STANDBY, 8'h00, 1'b0, 8'h00, 1'b0);
        run_op(ume_pkg::OP_GAP, 8'h00, 1'b0, 8'h00, 1'b0);
        run_op(ume_pkg::OP_HEADER, 8'h00, 1'b0, 8'h00, 1'b1);
        run_op(ume_pkg::OP_READ, 8'h00, 1'b0, 8'hC3, 1'b1);
        run_op(ume_pkg::OP_SEND, 8'h81, 1'b1, 8'h00, 1'b0);
    endtask

    task automatic test_long_phases();
        stretch_and_trim(ume_pkg::REG_STANDBY_HIGH, 16'hFFFF, 16'd3, ume_pkg::OP_STANDBY, 40);
        stretch_and_trim(ume_pkg::REG_SETUP, 16'hFFFF, 16'd1, ume_pkg::OP_GAP, 30);
        stretch_and_trim(ume_pkg::REG_HEADER_LOW, 16'hFFFF, 16'd2, ume_pkg::OP_HEADER, 30);
        // past the first sample at the widest quarter, then narrow it mid-bit
        stretch_and_trim(ume_pkg::REG_QUARTER, 16'd255, 16'd1, ume_pkg::OP_READ, 260);
    endtask

    task automatic test_short_ops();
        cfg_write(ume_pkg::REG_QUARTER, 16'd1);
        cfg_write(ume_pkg::REG_STANDBY_HIGH, 16'd1);
        cfg_write(ume_pkg::REG_SETUP, 16'd1);
        cfg_write(ume_pkg::REG_HEADER_LOW, 16'd1);
        run_op(ume_pkg::OP_STANDBY, 8'h00, 1'b0, 8'h00, 1'b0);
        run_op(ume_pkg::OP_GAP, 8'h00, 1'b0, 8'h00, 1'b0);
        // header acknowledge leaves the stored one alone
        run_op(ume_pkg::OP_SEND, 8'h00, 1'b0, 8'h00, 1'b1);
        run_op(ume_pkg::OP_HEADER, 8'h00, 1'b0, 8'h00, 1'b0);
        run_op(ume_pkg::OP_SEND, 8'hFF, 1'b1, 8'h00, 1'b0);
        run_op(ume_pkg::OP_HEADER, 8'h00, 1'b0, 8'h00, 1'b1);
        run_op(ume_pkg::OP_READ, 8'h00, 1'b1, 8'h00, 1'b1);
        run_op(ume_pkg::OP_READ, 8'hFF, 1'b0, 8'hFF, 1'b0);
        run_op(ume_pkg::OP_READ, 8'h00, 1'b1, 8'h5A, 1'b1);
        // idle high: tick and unknown op do nothing
        tick(1'b0);
        start_op(OP_UNUSED_LO + 3'd1, 8'h00, 1'b0);
        start_op(ume_pkg::OP_HEADER, 8'h00, 1'b0);
        start_op(ume_pkg::OP_SEND, 8'hFF, 1'b1);
        finish_op();
    endtask

    task automatic test_random_traffic();
        int base;
        int op_cnt;
        base   = items_sent;
        op_cnt = 0;
        while (items_sent < base + RANDOM_ITEMS)
        begin
            // no idling through the middle third
            steady = (items_sent > base + RANDOM_ITEMS / 3) &&
                     (items_sent < base + 2 * RANDOM_ITEMS / 3);
            if (op_cnt % 2 == 0)
            begin
                cfg_write(ume_pkg::REG_QUARTER, 16'($urandom_range(2, 0)));
                cfg_write(ume_pkg::REG_STANDBY_HIGH, 16'($urandom_range(6, 0)));
                cfg_write(ume_pkg::REG_SETUP, 16'($urandom_range(4, 0)));
                cfg_write(ume_pkg::REG_HEADER_LOW, 16'($urandom_range(4, 0)));
            end
            if ($urandom_range(9) == 0)
                tick(1'($urandom));
            if ($urandom_range(19) == 0)
                start_op(3'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO)), 8'($urandom),
                         1'($urandom));
            resp_byte = 8'($urandom);
            resp_sak  = 1'($urandom);
            noise_pct = ($urandom_range(99) < 15) ? 40 : 0;
            start_op(3'($urandom_range(ume_pkg::OP_READ, ume_pkg::OP_STANDBY)), 8'($urandom),
                     1'($urandom));
            while (!engine_idle())
            begin
                // stray start inside an op
                if ($urandom_range(99) < 2)
                    start_op(3'($urandom), 8'($urandom), 1'($urandom));
                else
                    tick(slave_level());
            end
            if ($urandom_range(9) == 0)
                drain();
            op_cnt++;
        end
        steady    = 1'b0;
        noise_pct = 0;
    endtask

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin : bus_result_check
        ume_pkg::result_t got;
        ume_pkg::result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.bus_drive  = m_tdata[0];
            got.bus_enable = m_tdata[1];
            got.busy_res   = m_tdata[2];
            got.done_res   = m_tdata[3];
            got.rx_byte    = m_tdata[11:4];
            got.sak_ok     = m_tdata[12];
            got.rejected   = m_tdata[13];
            if (pending_bus_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result with nothing pending, tdata %h", $time, m_tdata);
            end
            else
            begin
                want = pending_bus_results.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("%0t: exp drv %b en %b busy %b done %b rx %h sak %b rej %b",
                                 $time, want.bus_drive, want.bus_enable, want.busy_res,
                                 want.done_res, want.rx_byte, want.sak_ok, want.rejected);
                        $display("%0t: got drv %b en %b busy %b done %b rx %h sak %b rej %b",
                                 $time, got.bus_drive, got.bus_enable, got.busy_res,
                                 got.done_res, got.rx_byte, got.sak_ok, got.rejected);
                    end
                end
            end
        end
        m_tready <= steady || ($urandom_range(99) >= 8);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_CYCLES)
        begin
            $display("unio_bus_master_byte_engine_tb NOT OK");
            $finish;
        end
    end

    initial
    begin
        eng_phase = ume_pkg::PH_IDLE_REL;
        pos_cnt   = '0;
        bit_idx   = '0;
        shreg     = '0;
        first_smp = 1'b0;
        mak_q     = 1'b0;
        op_q      = ume_pkg::OP_STANDBY;
        rx_q      = '0;
        sak_q     = 1'b0;
        cfg       = {ume_pkg::RST_QUARTER, ume_pkg::RST_STANDBY_HIGH, ume_pkg::RST_SETUP,
                     ume_pkg::RST_HEADER_LOW};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_defaults();
        test_zero_registers();
        test_long_phases();
        test_short_ops();
        test_random_traffic();
        drain();
        if (mismatches == 0 && pending_bus_results.size() == 0)
            $display("unio_bus_master_byte_engine_tb OK");
        else
            $display("unio_bus_master_byte_engine_tb NOT OK");
        $finish;
    end

endmodule
